>>> src/fcet_pkg.sv
// Shared constants, register indexes and the fixed-point sqrt(2) helper
// for the Frei-Chen edge threshold block. No dependencies.
`timescale 1ns / 1ps

package fcet_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int SQRT2_FRAC_DEF = 16;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int THR_W      = 11;
    localparam int IMG_W_W    = 10;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [THR_W-1:0]   THRESHOLD_RST    = 11'd30;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 10'd512;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd512;

    localparam logic [PIX_W-1:0] EDGE_MARK  = 8'd0;
    localparam logic [PIX_W-1:0] PLAIN_MARK = 8'd255;

    // round(sqrt(2) * 2^frac_bits), evaluated at elaboration
    function automatic longint unsigned fcet_sqrt2_fixed(input int frac_bits);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bit_v;
        int              i;
        rem   = 64'd2 << (2 * frac_bits);
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res + ((rem > res) ? 64'd1 : 64'd0);
    endfunction

endpackage

>>> src/frei_chen_edge_threshold_top.sv
// Frei-Chen 3x3 edge threshold, top level. Uses fcet_pkg and fcet_ram.
// Path: line store stage, window stage, gradient and square registers, output register.
// Throughput: one pixel per cycle while the output is not stalled; a pixel that closes a
// row or lies on the last row causes up to 4 results, issued one per cycle by the window
// stage while it is not stalled, so such a pixel holds the input until all are issued.
// Reset: position, window, valids cleared, registers to defaults; line stores not.
`timescale 1ns / 1ps

module frei_chen_edge_threshold_top #(
    parameter int MAX_WIDTH       = fcet_pkg::MAX_WIDTH_DEF,
    parameter int SQRT2_FRAC_BITS = fcet_pkg::SQRT2_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fcet_pkg::PIX_W-1:0]      pixel_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fcet_pkg::PIX_W-1:0]      edge_value,
    output logic [fcet_pkg::ROW_W-1:0]      out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]    out_col,
    output logic                            last_of_run,
    output logic                            frame_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcet_pkg::CFG_DATA_W-1:0] cfg_data
);

    import fcet_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int GW    = SQRT2_FRAC_BITS + 11;
    localparam int SQW   = 2 * GW - 2;
    localparam int SHIFT = 2 * SQRT2_FRAC_BITS - 2;
    localparam int LW    = 2 * PIX_W;
    localparam int TSQ_W = 2 * (THR_W + 1);
    localparam logic signed [GW-1:0] SQRT2_K = GW'(fcet_sqrt2_fixed(SQRT2_FRAC_BITS));

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [CW-1:0]    col;
        logic             last;
        logic             fdone;
    } res_meta_t;

    // configuration
    logic [THR_W-1:0]   edge_threshold_reg;
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [THR_W:0]     thr_2m1;
    logic [TSQ_W-1:0]   thr_sq_reg;
    logic               thr_zero_reg;

    // position
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic [CW-1:0]    cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             cur_endc;
    logic             cur_endr;
    logic             accept;

    // line store stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_endc_reg;
    logic             s1_endr_reg;
    logic             s1_byp_reg;
    logic [LW-1:0]    fwd_reg;
    logic [LW-1:0]    ram_rdata;
    logic [PIX_W-1:0] s1_up;
    logic [PIX_W-1:0] s1_lo;
    logic             s1_adv;

    // window stage
    logic             w_valid_reg;
    logic [ROW_W-1:0] w_row_reg;
    logic [CW-1:0]    w_col_reg;
    logic             w_endr_reg;
    logic             w_endc_reg;
    logic             ri_reg;
    logic             ci_reg;
    logic [PIX_W-1:0] win_reg [3][3];
    logic             has_up;
    logic             has_left;
    logic             row_dec;
    logic             col_dec;
    logic             ri_last;
    logic             ci_last;
    logic             w_none;
    logic             w_issue;
    logic             w_done;
    logic             w_ready;
    logic [1:0]       rsel [3];
    logic [1:0]       csel [3];
    logic [PIX_W-1:0] p [3][3];
    logic signed [9:0] ax;
    logic signed [9:0] ay;
    logic signed [8:0] bx;
    logic signed [8:0] by;
    logic signed [GW-1:0] gx_next;
    logic signed [GW-1:0] gy_next;
    res_meta_t        w_meta;

    // arithmetic stages
    logic             p1_valid_reg;
    logic signed [GW-1:0] gx_reg;
    logic signed [GW-1:0] gy_reg;
    res_meta_t        p1_meta_reg;
    logic             p1_ready;
    logic signed [2*GW-1:0] prodx;
    logic signed [2*GW-1:0] prody;
    logic             p2_valid_reg;
    logic [SQW-1:0]   sqx_reg;
    logic [SQW-1:0]   sqy_reg;
    res_meta_t        p2_meta_reg;
    logic             p2_ready;
    logic [SQW:0]     mag_sum;
    logic             is_edge;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] edge_value_reg;
    res_meta_t        out_meta_reg;
    logic             o_ready;

    // window tap for one kernel offset, with edge replication
    function automatic logic [1:0] tap_index(input logic dec, input logic [1:0] k,
                                             input logic pos0, input logic pos1);
        logic [2:0] raw;
        logic [1:0] idx;
        logic [1:0] lowb;
        raw  = {1'b0, k} + (dec ? 3'd0 : 3'd1);
        idx  = (raw > 3'd2) ? 2'd2 : raw[1:0];
        lowb = pos0 ? 2'd2 : (pos1 ? 2'd1 : 2'd0);
        return (idx < lowb) ? lowb : idx;
    endfunction

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_threshold_reg <= THRESHOLD_RST;
            image_width_reg    <= IMAGE_WIDTH_RST;
            image_height_reg   <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // (2T-1)^2, compared against (gx^2+gy^2) >> SHIFT
    assign thr_2m1 = {edge_threshold_reg, 1'b0} - 1'b1;

    always_ff @(posedge clk)
    begin
        thr_sq_reg   <= TSQ_W'(thr_2m1) * TSQ_W'(thr_2m1);
        thr_zero_reg <= (edge_threshold_reg == '0);
    end

    //------------------------------------------------------------------
    // frame position
    //------------------------------------------------------------------
    always_comb
    begin
        if (image_width_reg == '0)
            w_last = '0;
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(image_width_reg - 1'b1);

        if (image_height_reg == '0)
            h_last = '0;
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(image_height_reg - 1'b1);
    end

    assign cur_col  = (col_count_reg > w_last) ? w_last : col_count_reg;
    assign cur_row  = (row_count_reg > h_last) ? h_last : row_count_reg;
    assign cur_endc = (cur_col == w_last);
    assign cur_endr = (cur_row == h_last);

    assign accept   = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s1_adv;

    //------------------------------------------------------------------
    // line stores: one word per column holds {row r-2, row r-1}
    //------------------------------------------------------------------
    fcet_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_fcet_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({s1_lo, s1_pix_reg}),
        .re    (accept),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    // bypass when the previous pixel wrote the same column in the read cycle
    assign {s1_up, s1_lo} = s1_byp_reg ? fwd_reg : ram_rdata;

    //------------------------------------------------------------------
    // window stage control
    //------------------------------------------------------------------
    assign has_up   = (w_row_reg != '0);
    assign has_left = (w_col_reg != '0);
    assign row_dec  = has_up && !ri_reg;
    assign col_dec  = has_left && !ci_reg;
    assign ri_last  = ri_reg || !(has_up && w_endr_reg);
    assign ci_last  = ci_reg || !(has_left && w_endc_reg);
    assign w_none   = !(has_up || w_endr_reg) || !(has_left || w_endc_reg);
    assign w_issue  = w_valid_reg && !w_none && p1_ready;
    assign w_done   = w_valid_reg && (w_none || (w_issue && ri_last && ci_last));
    assign w_ready  = !w_valid_reg || w_done;
    assign s1_adv   = s1_valid_reg && w_ready;

    assign p1_ready = !p1_valid_reg || p2_ready;
    assign p2_ready = !p2_valid_reg || o_ready;
    assign o_ready  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            w_valid_reg   <= 1'b0;
            ri_reg        <= 1'b0;
            ci_reg        <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (accept)
            begin
                if (cur_endc)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= cur_endr ? '0 : cur_row + 1'b1;
                end
                else
                begin
                    col_count_reg <= cur_col + 1'b1;
                    row_count_reg <= cur_row;
                end
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                w_valid_reg <= 1'b1;
            else if (w_done)
                w_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                ri_reg <= 1'b0;
                ci_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= s1_up;
                win_reg[1][2] <= s1_lo;
                win_reg[2][2] <= s1_pix_reg;
            end
            else if (w_issue)
            begin
                if (ci_last)
                begin
                    ci_reg <= 1'b0;
                    ri_reg <= !ri_last;
                end
                else
                begin
                    ci_reg <= 1'b1;
                end
            end

            if (p1_ready)
                p1_valid_reg <= w_issue;
            if (p2_ready)
                p2_valid_reg <= p1_valid_reg;
            if (o_ready)
                out_valid_reg <= p2_valid_reg;
        end
    end

    //------------------------------------------------------------------
    // kernel taps and gradients for the result being issued
    //------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rsel[k] = tap_index(row_dec, 2'(k), (w_row_reg == '0), (w_row_reg == ROW_W'(1)));
            csel[k] = tap_index(col_dec, 2'(k), (w_col_reg == '0), (w_col_reg == CW'(1)));
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p[i][j] = win_reg[rsel[i]][csel[j]];
            end
        end
    end

    assign ax = {2'b00, p[0][2]} + {2'b00, p[2][2]} - {2'b00, p[0][0]} - {2'b00, p[2][0]};
    assign ay = {2'b00, p[2][0]} + {2'b00, p[2][2]} - {2'b00, p[0][0]} - {2'b00, p[0][2]};
    assign bx = {1'b0, p[1][2]} - {1'b0, p[1][0]};
    assign by = {1'b0, p[2][1]} - {1'b0, p[0][1]};

    assign gx_next = (GW'(ax) <<< SQRT2_FRAC_BITS) + GW'(bx) * SQRT2_K;
    assign gy_next = (GW'(ay) <<< SQRT2_FRAC_BITS) + GW'(by) * SQRT2_K;

    assign w_meta.row   = row_dec ? w_row_reg - 1'b1 : w_row_reg;
    assign w_meta.col   = col_dec ? w_col_reg - 1'b1 : w_col_reg;
    assign w_meta.last  = ri_last && ci_last;
    assign w_meta.fdone = !row_dec && w_endr_reg && !col_dec && w_endc_reg;

    assign prodx   = gx_reg * gx_reg;
    assign prody   = gy_reg * gy_reg;
    assign mag_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    // low SHIFT bits of the scaled threshold are zero, so compare the high part
    assign is_edge = thr_zero_reg || (32'(mag_sum[SQW:SHIFT]) >= 32'(thr_sq_reg));

    //------------------------------------------------------------------
    // payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel_in;
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
            s1_endc_reg <= cur_endc;
            s1_endr_reg <= cur_endr;
            s1_byp_reg  <= s1_adv && (s1_col_reg == cur_col);
            fwd_reg     <= {s1_lo, s1_pix_reg};
        end
        if (s1_adv)
        begin
            w_row_reg  <= s1_row_reg;
            w_col_reg  <= s1_col_reg;
            w_endr_reg <= s1_endr_reg;
            w_endc_reg <= s1_endc_reg;
        end
        if (w_issue)
        begin
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            p1_meta_reg <= w_meta;
        end
        if (p2_ready && p1_valid_reg)
        begin
            sqx_reg     <= prodx[SQW-1:0];
            sqy_reg     <= prody[SQW-1:0];
            p2_meta_reg <= p1_meta_reg;
        end
        if (o_ready && p2_valid_reg)
        begin
            edge_value_reg <= is_edge ? EDGE_MARK : PLAIN_MARK;
            out_meta_reg   <= p2_meta_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign edge_value  = edge_value_reg;
    assign out_row     = out_meta_reg.row;
    assign out_col     = out_meta_reg.col;
    assign last_of_run = out_meta_reg.last;
    assign frame_done  = out_meta_reg.fdone;

endmodule

>>> src/fcet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fcet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and write to one address return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fcet_checker.sv
// Port-level checks for the Frei-Chen edge threshold top level, and its bind.
// Depends on frei_chen_edge_threshold_top being present.
`timescale 1ns / 1ps

module fcet_checker #(
    parameter int COL_W = 9
) (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [7:0]       edge_value,
    input logic [11:0]      out_row,
    input logic [COL_W-1:0] out_col,
    input logic             last_of_run,
    input logic             frame_done
);

    logic             out_acc;
    logic             after_done_reg;
    logic             in_run_reg;
    logic [11:0]      prev_row_reg;
    logic [COL_W-1:0] prev_col_reg;

    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_done_reg <= 1'b1;
            in_run_reg     <= 1'b0;
            prev_row_reg   <= '0;
            prev_col_reg   <= '0;
        end
        else if (out_acc)
        begin
            after_done_reg <= frame_done;
            in_run_reg     <= !last_of_run;
            prev_row_reg   <= out_row;
            prev_col_reg   <= out_col;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edge_value) && $stable(out_row)
            && $stable(out_col) && $stable(last_of_run) && $stable(frame_done))
        else $error("stalled result changed");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame end not last of its run");

    // a width change mid-row can move the first result off column zero
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && after_done_reg |-> out_row == '0)
        else $error("frame does not start at row zero");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && in_run_reg |->
            (out_row == prev_row_reg && out_col == prev_col_reg + 1'b1)
            || (out_row == prev_row_reg + 1'b1))
        else $error("results of one pixel out of raster order");

endmodule

bind frei_chen_edge_threshold_top fcet_checker #(
    .COL_W ($clog2(MAX_WIDTH))
) u_fcet_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .edge_value  (edge_value),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for frei_chen_edge_threshold_top: directed and random frames,
// with an edge map predictor class that checks every result in order.
// Depends on fcet_pkg and the block's RTL only.

module tb_top;
    import fcet_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     MAX_COLS      = 512;
    localparam int     MAX_ROWS      = 4096;
    localparam int     COL_W         = $clog2(MAX_COLS);
    localparam int     FRAC          = 16;
    localparam longint SQRT2_Q16     = 92682;
    localparam int     DRAIN_WAIT    = 16;
    localparam int     STALL_LIMIT   = 1500;
    localparam int     RANDOM_PIXELS = 200;
    localparam int     PRINT_CAP     = 40;

    typedef enum int {TEXTURE_NOISE, TEXTURE_FLAT, TEXTURE_STEP, TEXTURE_BINARY} texture_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } edge_mark_t;

    class edge_map_model;
        logic [THR_W-1:0]   threshold;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        logic [7:0]         row_above [MAX_COLS];
        logic [7:0]         row_prev  [MAX_COLS];
        logic [7:0]         win [9];
        int                 col_pos;
        int                 row_pos;
        int                 errors;
        edge_mark_t         pending [$];

        function new();
            threshold  = THRESHOLD_RST;
            width_reg  = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            foreach (row_above[i])
            begin
                row_above[i] = '0;
                row_prev[i]  = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function int clip(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int eff_width();
            return clip(int'(width_reg), 1, MAX_COLS);
        endfunction

        function int eff_height();
            return clip(int'(height_reg), 1, MAX_ROWS);
        endfunction

        // pixels still to come before the frame wraps, position saturated as the block does
        function int frame_left();
            int w;
            int h;
            w = eff_width();
            h = eff_height();
            return (h - clip(row_pos, 0, h - 1) - 1) * w + (w - clip(col_pos, 0, w - 1));
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EDGE_THRESHOLD: threshold  = data[THR_W-1:0];
                CFG_IMAGE_WIDTH:    width_reg  = data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   height_reg = data[IMG_H_W-1:0];
                default: ;
            endcase
        endfunction

        // round(|g|) >= T  <=>  gx^2 + gy^2 >= (2T-1)^2 / 4, gradients in Q16
        function bit is_edge(input int p[9]);
            longint gx;
            longint gy;
            longint lim;
            if (threshold == 0)
                return 1'b1;
            gx  = longint'(p[2] + p[8] - p[0] - p[6]) * (64'sd1 << FRAC)
                + longint'(p[5] - p[3]) * SQRT2_Q16;
            gy  = longint'(p[6] + p[8] - p[0] - p[2]) * (64'sd1 << FRAC)
                + longint'(p[7] - p[1]) * SQRT2_Q16;
            lim = longint'(2 * int'(threshold) - 1);
            lim = (lim * lim) << (2 * FRAC - 2);
            return (gx * gx + gy * gy) >= lim;
        endfunction

        function void take_pixel(logic [7:0] pix);
            int         w;
            int         h;
            int         c;
            int         r;
            int         nr;
            int         nc;
            int         n;
            int         i;
            int         j;
            int         k;
            int         rr;
            int         cc;
            int         orows [2];
            int         ocols [2];
            int         p [9];
            logic [7:0] up;
            logic [7:0] lo;
            edge_mark_t outs [4];
            w = eff_width();
            h = eff_height();
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            up = row_above[c];
            lo = row_prev[c];
            row_above[c] = lo;
            row_prev[c]  = pix;
            for (i = 0; i < 3; i++)
            begin
                win[i * 3]     = win[i * 3 + 1];
                win[i * 3 + 1] = win[i * 3 + 2];
            end
            win[2] = up;
            win[5] = lo;
            win[8] = pix;

            nr = 0;
            nc = 0;
            if (r >= 1)
            begin
                orows[nr] = r - 1;
                nr++;
            end
            if (r == h - 1)
            begin
                orows[nr] = r;
                nr++;
            end
            if (c >= 1)
            begin
                ocols[nc] = c - 1;
                nc++;
            end
            if (c == w - 1)
            begin
                ocols[nc] = c;
                nc++;
            end

            n = 0;
            for (i = 0; i < nr; i++)
            begin
                for (j = 0; j < nc; j++)
                begin
                    // border replication: clamp to the frame, then into the 3x3 window
                    for (k = 0; k < 9; k++)
                    begin
                        rr = clip(clip(orows[i] + k / 3 - 1, 0, h - 1) - r + 2, 0, 2);
                        cc = clip(clip(ocols[j] + k % 3 - 1, 0, w - 1) - c + 2, 0, 2);
                        p[k] = int'(win[rr * 3 + cc]);
                    end
                    outs[n].value = is_edge(p) ? EDGE_MARK : PLAIN_MARK;
                    outs[n].row   = ROW_W'(orows[i]);
                    outs[n].col   = COL_W'(ocols[j]);
                    outs[n].last  = 1'b0;
                    outs[n].done  = (orows[i] == h - 1) && (ocols[j] == w - 1);
                    n++;
                end
            end
            if (n > 0)
                outs[n - 1].last = 1'b1;
            for (i = 0; i < n; i++)
                pending.push_back(outs[i]);

            if (c == w - 1)
            begin
                col_pos = 0;
                row_pos = (r == h - 1) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_mark(edge_mark_t got);
            edge_mark_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                          got.row, got.col));
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("edge_value at (%0d,%0d): got %0d want %0d",
                                          want.row, want.col, got.value, want.value));
            if (got.row !== want.row)
                report_mismatch($sformatf("out_row: got %0d want %0d", got.row, want.row));
            if (got.col !== want.col)
                report_mismatch($sformatf("out_col: got %0d want %0d", got.col, want.col));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_of_run at (%0d,%0d): got %b want %b",
                                          want.row, want.col, got.last, want.last));
            if (got.done !== want.done)
                report_mismatch($sformatf("frame_done at (%0d,%0d): got %b want %b",
                                          want.row, want.col, got.done, want.done));
        endtask
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_in   = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [PIX_W-1:0]      edge_value;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  last_of_run;
    logic                  frame_done;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    edge_map_model marks = new();
    bit            calm        = 1'b0;
    int            pixels_sent = 0;
    int            idle_cycles = 0;

    frei_chen_edge_threshold_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .edge_value  (edge_value),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_done  (frame_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] make_pixel(texture_t tex, int base);
        int v;
        case (tex)
            TEXTURE_NOISE: v = $urandom_range(0, 255);
            TEXTURE_FLAT:  v = base + $urandom_range(0, 8) - 4;
            TEXTURE_STEP:  v = ((marks.col_pos < marks.eff_width() / 2) ? base : 255 - base)
                               + $urandom_range(0, 4);
            default:       v = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    initial
    begin : stall_gen
        int n;
        forever
        begin
            n = pick_pause();
            if (n > 0)
            begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) out_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            marks.check_mark({edge_value, out_row, out_col, last_of_run, frame_done});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        gap = pick_pause();
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (in_stall);
        marks.take_pixel(pix);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input texture_t tex);
        int base;
        base = (tex == TEXTURE_STEP) ? $urandom_range(0, 100) : $urandom_range(0, 255);
        repeat (count) send_pixel(make_pixel(tex, base));
    endtask

    // wait for every pending result, then let row-0 pixels clear the pipeline
    task automatic settle();
        @(negedge clk) in_valid <= 1'b0;
        while (marks.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        marks.set_reg(idx, CFG_DATA_W'(val));
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    function automatic int pick_threshold();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 1;
        if (roll == 2)
            return 2047;
        return $urandom_range(2, 600);
    endfunction

    task automatic random_phase();
        int       roll;
        int       left;
        texture_t tex;
        calm = ($urandom_range(0, 4) == 0);
        settle();
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_EDGE_THRESHOLD, pick_threshold());
        roll = $urandom_range(0, 19);
        write_reg(CFG_IMAGE_WIDTH, (roll == 0) ? 0 :
                  ((roll == 1) ? $urandom_range(11, 40) : $urandom_range(1, 8)));
        roll = $urandom_range(0, 19);
        write_reg(CFG_IMAGE_HEIGHT, (roll == 0) ? 0 :
                  ((roll == 1) ? $urandom_range(7, 12) : $urandom_range(1, 6)));
        tex  = texture_t'($urandom_range(0, 3));
        left = marks.frame_left();
        if (left > 1 && $urandom_range(0, 5) == 0)
        begin
            // stop mid-frame and shrink; the position saturates into the smaller frame
            send_run($urandom_range(1, left - 1), tex);
            settle();
            write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, marks.eff_width()));
            write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, marks.eff_height()));
            write_reg(CFG_EDGE_THRESHOLD, pick_threshold());
            left = marks.frame_left();
        end
        send_run(left, tex);
    endtask

    initial
    begin : stimulus
        int start;
        int i;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // zero threshold, zero width and height: 1x1 frames, all edges
        write_reg(CFG_EDGE_THRESHOLD, 0);
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_pixel(8'd255);
        send_pixel(8'd0);

        settle();
        write_reg(CFG_EDGE_THRESHOLD, 1);
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        repeat (8) send_pixel(8'd0);
        send_pixel(8'd255);

        // oversize height, then shrink both dimensions in the middle of row 1
        settle();
        write_reg(CFG_EDGE_THRESHOLD, 2047);
        write_reg(CFG_IMAGE_WIDTH, 4);
        write_reg(CFG_IMAGE_HEIGHT, 8191);
        for (i = 0; i < 6; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        write_reg(CFG_EDGE_THRESHOLD, 700);
        send_pixel(8'd255);

        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
            random_phase();

        // oversize width, then shrink in the middle of row 0; the column saturates
        calm = 1'b0;
        settle();
        write_reg(CFG_EDGE_THRESHOLD, $urandom_range(20, 300));
        write_reg(CFG_IMAGE_WIDTH, 1023);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_run(4, TEXTURE_STEP);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 3);
        send_run(marks.frame_left(), TEXTURE_STEP);

        settle();
        if (marks.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
